// ===== rtl/core/ctds_pkg.sv =====
// Shared types and constants for the Coulomb trap descent step block.
package ctds_pkg;

    // Bit-serial divider operand width
    localparam int DIV_W = 64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_IMB  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFT_SQ     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_MOB   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT  = 3'd5;

    // Mode code that holds x
    localparam logic [1:0] MODE_HOLD_X = 2'd2;

    // Unit charge factor, Q4.12
    localparam logic [15:0] UNIT_Q12 = 16'd4096;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/core/ctds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ctds_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/ctds_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module ctds_div
    import ctds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CW = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quot_reg;

    logic [DIV_W:0]   rem_shift;
    logic             fits;

    assign rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
                quot_reg <= '0;
            end else if (busy_reg) begin
                // remainder stays below the divisor, so the top bit drops safely
                rem_reg  <= fits ? DIV_W'(rem_shift - {1'b0, dvs_reg}) : rem_shift[DIV_W-1:0];
                quot_reg <= {quot_reg[DIV_W-2:0], fits};
                dvd_reg  <= {dvd_reg[DIV_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

// ===== rtl/core/coulomb_trap_descent_step.sv =====
// Top level: particle store and gradient-descent step sequencer.
//
// Input channel (s_valid/s_ready): a load transfer (s_req_type 0) writes one
// particle's position into the store and gives no result.
// An update transfer (s_req_type 1) names a particle; one result transfer on
// the m_ channel carries its position after one descent step.
// s_ready is high only while the sequencer is idle. An update walks every
// other particle below particle_count one at a time through one shared
// multiplier, an iterative square root and a shared bit-serial divider
// (six divisions per pair, four with x held). Immobile particles skip
// the pair walk.
// The result sits in an output register: the block goes idle and takes the
// next transfer while the receiver stalls; a second update waits at its end
// until the output register is free.
// Reset (synchronous, active low) clears the sequencer, the output valid and
// loads the configuration reset values. The store is not cleared: reload it.
// Configuration writes are taken at any edge with cfg_wr_en high.
module coulomb_trap_descent_step
    import ctds_pkg::*;
#(
    parameter int MAX_PARTICLES = 128,
    parameter int COORD_BITS    = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [30:0]           cfg_wr_data,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [6:0]            s_particle_index,
    input  logic signed [31:0]    s_pos_x,
    input  logic signed [31:0]    s_pos_y,
    input  logic signed [31:0]    s_pos_z,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [6:0]            m_result_index,
    output logic signed [31:0]    m_new_x,
    output logic signed [31:0]    m_new_y,
    output logic signed [31:0]    m_new_z,
    output logic                  m_saturated
);

    // Coordinate width kept in the store and in the clip range
    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int NW = $clog2(MAX_PARTICLES + 1);
    localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] CMIN = -CMAX - 64'sd1;
    localparam int SW = 47;                    // distance squared, Q27.20
    localparam logic [SW-1:0] S_SPLIT = SW'(64'd1 << 44);

    typedef enum logic [3:0] {
        S_IDLE, S_OWN, S_PAIR, S_DIFF, S_MWAIT, S_SQ, S_SCHK, S_SQRT,
        S_CSTART, S_DWAIT, S_CDONE, S_TSTART, S_TDONE, S_FINAL, S_FSTEP, S_OUT
    } state_t;

    // Clip to the coordinate range; the top bit flags a clip.
    function automatic logic [CW:0] clip_c(input logic signed [63:0] v);
        logic [CW:0] res;
        if (v > CMAX) begin
            res = {1'b1, CMAX[CW-1:0]};
        end else if (v < CMIN) begin
            res = {1'b1, CMIN[CW-1:0]};
        end else begin
            res = {1'b0, v[CW-1:0]};
        end
        return res;
    endfunction

    // configuration
    logic [1:0]  mode_reg;
    logic [15:0] imb_reg;
    logic [30:0] soft_reg;
    logic [15:0] step_reg;
    logic [7:0]  fm_reg;
    logic [7:0]  pc_reg;

    // sequencer
    state_t state_reg;
    state_t ret_reg;
    logic [6:0]    idx_reg;
    logic [AW-1:0] slot_reg;
    logic [NW-1:0] j_reg;
    logic [NW-1:0] n_cnt;
    logic [1:0]    ax_reg;
    logic [4:0]    sq_cnt_reg;
    logic          flag_reg;

    logic signed [CW-1:0] o_reg [3];
    logic signed [CW-1:0] nw_reg [3];
    logic signed [32:0]   d_reg [3];
    logic signed [63:0]   f_reg [3];
    logic [SW-1:0]        s_reg;
    logic [63:0]          v_reg;
    logic [63:0]          r_reg;
    logic [63:0]          bit_reg;
    logic [33:0]          q_now;
    logic [31:0]          pp_reg;

    // shared multiplier
    logic signed [33:0]   mul_a_reg;
    logic signed [33:0]   mul_b_reg;
    logic signed [67:0]   prod_reg;

    // output register
    logic                 m_valid_reg;
    logic [6:0]           m_idx_reg;
    logic signed [CW-1:0] m_x_reg;
    logic signed [CW-1:0] m_y_reg;
    logic signed [CW-1:0] m_z_reg;
    logic                 m_sat_reg;

    // store
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [3*CW-1:0] ram_wdata;
    logic [3*CW-1:0] ram_rdata;
    logic            ram_we;
    logic [AW-1:0]   slot_now;
    logic [CW:0]     ld_x;
    logic [CW:0]     ld_y;
    logic [CW:0]     ld_z;
    logic signed [CW-1:0] rd_c [3];

    // divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    // combinational helpers
    logic            accept;
    logic            move_x;
    logic            skip_x;
    logic [32:0]     d_mag;
    logic [64:0]     r_try;
    logic            sq_take;
    logic signed [67:0] vsum;
    logic signed [67:0] new_full;
    logic [CW:0]     f_clip;
    logic [CW:0]     n_clip;
    logic [15:0]     pj;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign move_x    = (mode_reg != MODE_HOLD_X);
    assign skip_x    = (ax_reg == 2'd0) && !move_x;

    // map the particle index onto a store slot
    always_comb begin
        slot_now = '0;
        for (int i = 0; i < 128; i++) begin
            if (s_particle_index == 7'(i)) begin
                slot_now = AW'(i % MAX_PARTICLES);
            end
        end
    end

    assign n_cnt     = (32'(pc_reg) > 32'(MAX_PARTICLES)) ? NW'(MAX_PARTICLES)
                                                           : NW'(pc_reg);

    // clip loaded coordinates into the store range
    assign ld_x      = clip_c(64'(s_pos_x));
    assign ld_y      = clip_c(64'(s_pos_y));
    assign ld_z      = clip_c(64'(s_pos_z));
    assign ram_we    = accept && !s_req_type;
    assign ram_waddr = slot_now;
    assign ram_wdata = {ld_z[CW-1:0], ld_y[CW-1:0], ld_x[CW-1:0]};
    assign ram_raddr = (state_reg == S_IDLE) ? slot_now : j_reg[AW-1:0];
    assign rd_c[0]   = ram_rdata[CW-1:0];
    assign rd_c[1]   = ram_rdata[2*CW-1:CW];
    assign rd_c[2]   = ram_rdata[3*CW-1:2*CW];

    ctds_ram #(
        .WIDTH (3 * CW),
        .DEPTH (MAX_PARTICLES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // pair distance, Q14.20; r_reg holds the root from the end of S_SQRT on
    assign q_now = (s_reg < S_SPLIT) ? 34'(r_reg[31:0]) : {r_reg[23:0], 10'd0};

    // divider requests: direction cosine, then pair term
    assign d_mag = d_reg[ax_reg][32] ? 33'(-d_reg[ax_reg]) : 33'(d_reg[ax_reg]);
    always_comb begin
        div_req.start    = ((state_reg == S_CSTART) && !skip_x) || (state_reg == S_TSTART);
        div_req.dividend = {2'b00, d_mag[31:0], 30'd0};
        div_req.divisor  = 64'(q_now);
        if (state_reg == S_TSTART) begin
            div_req.dividend = prod_reg[63:0];
            div_req.divisor  = 64'(s_reg) << 14;
        end
    end

    ctds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // square root step
    assign r_try   = {1'b0, r_reg} + {1'b0, bit_reg};
    assign sq_take = {1'b0, v_reg} >= r_try;

    // step scaling with round half up, floor division by 2^16
    assign vsum     = prod_reg + 68'sd32768;
    assign new_full = 68'(o_reg[ax_reg]) + (vsum >>> 16);
    assign f_clip   = clip_c(f_reg[ax_reg]);
    assign n_clip   = clip_c(new_full[63:0]);
    assign pj       = j_reg[0] ? imb_reg : UNIT_Q12;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 2'd3;
            imb_reg  <= UNIT_Q12;
            soft_reg <= '0;
            step_reg <= 16'd655;
            fm_reg   <= '0;
            pc_reg   <= 8'd96;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DIM_MODE:   mode_reg <= cfg_wr_data[1:0];
                REG_CHARGE_IMB: imb_reg  <= cfg_wr_data[15:0];
                REG_SOFT_SQ:    soft_reg <= cfg_wr_data;
                REG_STEP_SIZE:  step_reg <= cfg_wr_data[15:0];
                REG_FIRST_MOB:  fm_reg   <= cfg_wr_data[7:0];
                REG_PART_COUNT: pc_reg   <= cfg_wr_data[7:0];
                default: ;
            endcase
        end
    end

    // product register runs every cycle on the held operands
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a_reg * mul_b_reg;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // drop valid after a transfer unless a new result loads this cycle
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept && s_req_type) begin
                        idx_reg   <= s_particle_index;
                        slot_reg  <= slot_now;
                        state_reg <= S_OWN;
                    end
                end
                S_OWN: begin
                    flag_reg <= 1'b0;
                    j_reg    <= '0;
                    for (int k = 0; k < 3; k++) begin
                        o_reg[k]  <= rd_c[k];
                        nw_reg[k] <= rd_c[k];
                        f_reg[k]  <= -(64'(rd_c[k]) <<< 1);
                    end
                    if (32'(slot_reg) < 32'(fm_reg)) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_PAIR;
                    end
                end
                S_PAIR: begin
                    if (j_reg >= n_cnt) begin
                        ax_reg    <= 2'd0;
                        state_reg <= S_FINAL;
                    end else if (j_reg == NW'(slot_reg)) begin
                        j_reg <= j_reg + 1'b1;
                    end else begin
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    for (int k = 0; k < 3; k++) begin
                        d_reg[k] <= 33'(o_reg[k]) - 33'(rd_c[k]);
                    end
                    mul_a_reg <= 34'(33'(o_reg[0]) - 33'(rd_c[0]));
                    mul_b_reg <= 34'(33'(o_reg[0]) - 33'(rd_c[0]));
                    s_reg     <= SW'(soft_reg);
                    ax_reg    <= 2'd0;
                    ret_reg   <= S_SQ;
                    state_reg <= S_MWAIT;
                end
                S_MWAIT: begin
                    state_reg <= ret_reg;
                end
                S_SQ: begin
                    // accumulate floor(d*d / 2^20) per axis
                    s_reg <= s_reg + SW'(prod_reg[63:20]);
                    if (ax_reg == 2'd2) begin
                        state_reg <= S_SCHK;
                    end else begin
                        mul_a_reg <= 34'(d_reg[ax_reg + 2'd1]);
                        mul_b_reg <= 34'(d_reg[ax_reg + 2'd1]);
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_MWAIT;
                    end
                end
                S_SCHK: begin
                    if (s_reg == '0) begin
                        // coincident pair with no softening: no force, flag it
                        flag_reg  <= 1'b1;
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_PAIR;
                    end else begin
                        v_reg      <= (s_reg < S_SPLIT) ? (64'(s_reg) << 20) : 64'(s_reg);
                        r_reg      <= '0;
                        bit_reg    <= 64'd1 << 62;
                        sq_cnt_reg <= '0;
                        mul_a_reg  <= 34'(slot_reg[0] ? imb_reg : UNIT_Q12);
                        mul_b_reg  <= 34'(pj);
                        state_reg  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sq_take) begin
                        v_reg <= v_reg - r_try[63:0];
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg    <= bit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 5'd31) begin
                        state_reg <= S_CSTART;
                        ax_reg    <= 2'd0;
                        pp_reg    <= prod_reg[31:0];
                    end
                end
                S_CSTART: begin
                    // square root is final in r_reg from here on
                    if (skip_x) begin
                        ax_reg <= 2'd1;
                    end else begin
                        ret_reg   <= S_CDONE;
                        state_reg <= S_DWAIT;
                    end
                end
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= ret_reg;
                    end
                end
                S_CDONE: begin
                    // clamp the direction cosine to 2^31
                    mul_a_reg <= (div_rsp.quot > 64'h8000_0000) ? 34'h0_8000_0000
                                                                : 34'(div_rsp.quot[31:0]);
                    mul_b_reg <= 34'(pp_reg);
                    ret_reg   <= S_TSTART;
                    state_reg <= S_MWAIT;
                end
                S_TSTART: begin
                    ret_reg   <= S_TDONE;
                    state_reg <= S_DWAIT;
                end
                S_TDONE: begin
                    if (d_reg[ax_reg][32]) begin
                        f_reg[ax_reg] <= f_reg[ax_reg] - $signed(div_rsp.quot);
                    end else begin
                        f_reg[ax_reg] <= f_reg[ax_reg] + $signed(div_rsp.quot);
                    end
                    if (ax_reg == 2'd2) begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_PAIR;
                    end else begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_CSTART;
                    end
                end
                S_FINAL: begin
                    if (skip_x) begin
                        ax_reg <= 2'd1;
                    end else begin
                        flag_reg  <= flag_reg | f_clip[CW];
                        mul_a_reg <= 34'($signed(f_clip[CW-1:0]));
                        mul_b_reg <= 34'(step_reg);
                        ret_reg   <= S_FSTEP;
                        state_reg <= S_MWAIT;
                    end
                end
                S_FSTEP: begin
                    nw_reg[ax_reg] <= n_clip[CW-1:0];
                    flag_reg       <= flag_reg | n_clip[CW];
                    if (ax_reg == 2'd2) begin
                        state_reg <= S_OUT;
                    end else begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= S_FINAL;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= idx_reg;
                        m_x_reg     <= nw_reg[0];
                        m_y_reg     <= nw_reg[1];
                        m_z_reg     <= nw_reg[2];
                        m_sat_reg   <= flag_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_idx_reg;
    assign m_new_x        = 32'(m_x_reg);
    assign m_new_y        = 32'(m_y_reg);
    assign m_new_z        = 32'(m_z_reg);
    assign m_saturated    = m_sat_reg;

endmodule

// ===== sim/testbench.sv =====
// Testbench for coulomb_trap_descent_step: directed and random load/update traffic.
`timescale 1ns / 100ps

module testbench;
    import ctds_pkg::*;

    localparam int  NPART       = 128;
    localparam bit  REQ_LOAD    = 1'b0;
    localparam bit  REQ_UPDATE  = 1'b1;
    localparam int  ONE_Q20     = 1 << 20;
    localparam int  SETTLE_CYC  = 20;
    localparam int  HOLDOFF_CYC = 3000;

    typedef struct {
        bit [6:0]           idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        bit                 sat;
    } step_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [30:0]          cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_req_type;
    logic [6:0]           s_particle_index;
    logic signed [31:0]   s_pos_x;
    logic signed [31:0]   s_pos_y;
    logic signed [31:0]   s_pos_z;
    logic                 m_valid;
    logic                 m_ready;
    logic [6:0]           m_result_index;
    logic signed [31:0]   m_new_x;
    logic signed [31:0]   m_new_y;
    logic signed [31:0]   m_new_z;
    logic                 m_saturated;

    // Mirror of the particle store and configuration
    longint   mir_x [NPART];
    longint   mir_y [NPART];
    longint   mir_z [NPART];
    bit       loaded [NPART];
    bit [1:0]  dim_mode;
    bit [15:0] imbalance;
    bit [30:0] soft_sq;
    bit [15:0] step_q16;
    bit [7:0]  first_mob;
    bit [7:0]  part_count;

    step_result_t pending_steps[$];
    int  fail_cnt;
    bit  idling_on;
    int  holdoff_left;

    coulomb_trap_descent_step u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard limit on the run
    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit [63:0] magnitude(longint d);
        return d < 0 ? bit'(0) - 64'(d) : 64'(d);
    endfunction

    function automatic longint clip_coord(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint coulomb_axis(longint d, bit [63:0] s, bit [63:0] q,
                                            bit [63:0] pp);
        bit [63:0] c;
        bit [63:0] t;
        c = (magnitude(d) << 30) / q;
        if (c > (64'd1 << 31)) c = 64'd1 << 31;
        t = (c * pp) / (s << 14);
        return d < 0 ? -longint'(t) : longint'(t);
    endfunction

    function automatic longint descent_delta(longint f);
        longint v;
        v = f * longint'(step_q16) + 32768;
        return v >>> 16;
    endfunction

    // Work out the position after one descent step for particle idx
    function automatic step_result_t descend(bit [6:0] idx);
        step_result_t res;
        bit        sat;
        bit        move_x;
        int        n;
        longint    ox, oy, oz, nx, ny, nz, fx, fy, fz, dx, dy, dz;
        bit [63:0] s, q, pp, p_own;
        sat = 1'b0;
        ox = mir_x[idx]; oy = mir_y[idx]; oz = mir_z[idx];
        nx = ox; ny = oy; nz = oz;
        if (idx >= first_mob) begin
            move_x = dim_mode != MODE_HOLD_X;
            n = part_count > NPART ? NPART : part_count;
            p_own = idx[0] ? 64'(imbalance) : 64'(UNIT_Q12);
            fx = -2 * ox; fy = -2 * oy; fz = -2 * oz;
            for (int j = 0; j < n; j++) begin
                if (j == idx) continue;
                dx = ox - mir_x[j]; dy = oy - mir_y[j]; dz = oz - mir_z[j];
                s = ((magnitude(dx) * magnitude(dx)) >> 20)
                  + ((magnitude(dy) * magnitude(dy)) >> 20)
                  + ((magnitude(dz) * magnitude(dz)) >> 20) + 64'(soft_sq);
                if (s == 0) begin
                    sat = 1'b1;
                    continue;
                end
                q = s < (64'd1 << 44) ? int_sqrt(s << 20) : int_sqrt(s) << 10;
                pp = p_own * ((j % 2) ? 64'(imbalance) : 64'(UNIT_Q12));
                if (move_x) fx += coulomb_axis(dx, s, q, pp);
                fy += coulomb_axis(dy, s, q, pp);
                fz += coulomb_axis(dz, s, q, pp);
            end
            if (move_x) begin
                fx = clip_coord(fx, sat);
                nx = clip_coord(ox + descent_delta(fx), sat);
            end
            fy = clip_coord(fy, sat);
            fz = clip_coord(fz, sat);
            ny = clip_coord(oy + descent_delta(fy), sat);
            nz = clip_coord(oz + descent_delta(fz), sat);
        end
        res.idx = idx;
        res.x = nx[31:0]; res.y = ny[31:0]; res.z = nz[31:0];
        res.sat = sat;
        return res;
    endfunction

    // ---------------- stimulus side ----------------
    // Send one transfer; valid stays high on return so a back-to-back item
    // can follow in the same step.
    task automatic send_item(bit kind, bit [6:0] idx, int x, int y, int z);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= kind;
        s_particle_index <= idx;
        s_pos_x          <= x;
        s_pos_y          <= y;
        s_pos_z          <= z;
        do @(posedge aclk); while (!s_ready);
        if (kind == REQ_LOAD) begin
            mir_x[idx] = x; mir_y[idx] = y; mir_z[idx] = z;
            loaded[idx] = 1'b1;
        end else begin
            pending_steps.push_back(descend(idx));
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, bit [30:0] val);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            REG_DIM_MODE:   dim_mode   = val[1:0];
            REG_CHARGE_IMB: imbalance  = val[15:0];
            REG_SOFT_SQ:    soft_sq    = val;
            REG_STEP_SIZE:  step_q16   = val[15:0];
            REG_FIRST_MOB:  first_mob  = val[7:0];
            REG_PART_COUNT: part_count = val[7:0];
            default: ;
        endcase
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return int'($urandom);
            2:       return 32'sh7FFF_FFFF;
            3:       return 32'sh8000_0000;
            default: return $urandom_range(0, 8 * ONE_Q20) - 4 * ONE_Q20;
        endcase
    endfunction

    task automatic load_random(bit [6:0] idx);
        send_item(REQ_LOAD, idx, rand_coord(), rand_coord(), rand_coord());
    endtask

    // ---------------- result side ----------------
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest expected step
    always @(posedge aclk) begin
        step_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_steps.size() == 0) begin
                $error("result transfer with nothing expected, index %0d", m_result_index);
                fail_cnt++;
            end else begin
                want = pending_steps.pop_front();
                if (m_result_index !== want.idx) begin
                    $error("result_index: expected %0d, got %0d", want.idx, m_result_index);
                    fail_cnt++;
                end
                if (m_new_x !== want.x) begin
                    $error("new_x: expected %0d, got %0d", want.x, m_new_x);
                    fail_cnt++;
                end
                if (m_new_y !== want.y) begin
                    $error("new_y: expected %0d, got %0d", want.y, m_new_y);
                    fail_cnt++;
                end
                if (m_new_z !== want.z) begin
                    $error("new_z: expected %0d, got %0d", want.z, m_new_z);
                    fail_cnt++;
                end
                if (m_saturated !== want.sat) begin
                    $error("saturated: expected %0d, got %0d", want.sat, m_saturated);
                    fail_cnt++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    // Coordinate extremes, zero distance, both modes, immobile and unused indexes
    task automatic test_directed();
        cfg_write(REG_PART_COUNT, 3);
        send_item(REQ_LOAD, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_item(REQ_LOAD, 1, 32'sh8000_0000, 32'sh7FFF_FFFF, -1);
        send_item(REQ_LOAD, 2, ONE_Q20, -ONE_Q20, 2 * ONE_Q20);
        send_item(REQ_UPDATE, 0, 0, 0, 0);
        send_item(REQ_UPDATE, 1, 0, 0, 0);
        send_item(REQ_UPDATE, 2, 0, 0, 0);
        // coincident particles with no softening
        send_item(REQ_LOAD, 2, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_item(REQ_UPDATE, 0, 0, 0, 0);
        cfg_write(REG_SOFT_SQ, 31'h7FFF_FFFF);
        send_item(REQ_UPDATE, 2, 0, 0, 0);
        cfg_write(REG_DIM_MODE, MODE_HOLD_X);
        send_item(REQ_UPDATE, 1, 0, 0, 0);
        cfg_write(REG_CHARGE_IMB, 16'hFFFF);
        cfg_write(REG_STEP_SIZE, 16'hFFFF);
        cfg_write(REG_SOFT_SQ, 0);
        send_item(REQ_LOAD, 2, ONE_Q20 / 2, ONE_Q20 / 4, -ONE_Q20 / 8);
        send_item(REQ_UPDATE, 1, 0, 0, 0);
        cfg_write(REG_FIRST_MOB, 2);
        send_item(REQ_UPDATE, 1, 0, 0, 0);
        send_item(REQ_UPDATE, 2, 0, 0, 0);
        // index outside the particles in use
        send_item(REQ_LOAD, 127, -3 * ONE_Q20, ONE_Q20, 0);
        send_item(REQ_UPDATE, 127, 0, 0, 0);
        cfg_write(REG_PART_COUNT, 0);
        send_item(REQ_UPDATE, 127, 0, 0, 0);
        cfg_write(REG_STEP_SIZE, 0);
        cfg_write(REG_FIRST_MOB, 0);
        send_item(REQ_UPDATE, 0, 0, 0, 0);
    endtask

    // One setting of the registers, then a mix of loads and updates
    task automatic test_random_phase(int count, int n_items, bit hold_off);
        int n_used;
        bit [6:0] idx;
        cfg_write(REG_PART_COUNT, count);
        cfg_write(REG_DIM_MODE, $urandom_range(0, 3));
        case ($urandom_range(0, 2))
            0:       cfg_write(REG_CHARGE_IMB, 4096);
            1:       cfg_write(REG_CHARGE_IMB, 16'hFFFF);
            default: cfg_write(REG_CHARGE_IMB, $urandom_range(4096, 65535));
        endcase
        case ($urandom_range(0, 3))
            0:       cfg_write(REG_SOFT_SQ, 0);
            1:       cfg_write(REG_SOFT_SQ, 31'h7FFF_FFFF);
            2:       cfg_write(REG_SOFT_SQ, $urandom);
            default: cfg_write(REG_SOFT_SQ, $urandom_range(0, ONE_Q20));
        endcase
        case ($urandom_range(0, 3))
            0:       cfg_write(REG_STEP_SIZE, 0);
            1:       cfg_write(REG_STEP_SIZE, 16'hFFFF);
            default: cfg_write(REG_STEP_SIZE, $urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 5))
            0:       cfg_write(REG_FIRST_MOB, 128);
            1:       cfg_write(REG_FIRST_MOB, $urandom_range(0, 255));
            2, 3:    cfg_write(REG_FIRST_MOB, $urandom_range(0, count + 1));
            default: cfg_write(REG_FIRST_MOB, 0);
        endcase
        n_used = count > NPART ? NPART : count;
        if (n_used == 0) n_used = 1;
        // every particle that an update reads must hold a position
        for (int j = 0; j < n_used; j++) begin
            if (!loaded[j]) load_random(j);
        end
        if (hold_off) holdoff_left = HOLDOFF_CYC;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                if ($urandom_range(0, 9) == 0) begin
                    // duplicate a particle so the pair distance is zero
                    idx = $urandom_range(0, n_used - 1);
                    send_item(REQ_LOAD, $urandom_range(0, 127), mir_x[idx], mir_y[idx],
                              mir_z[idx]);
                end else begin
                    load_random($urandom_range(0, 127));
                end
            end else begin
                do idx = $urandom_range(0, 127); while (!loaded[idx]);
                if ($urandom_range(0, 1) == 0) idx = $urandom_range(0, n_used - 1);
                send_item(REQ_UPDATE, idx, int'($urandom), int'($urandom), int'($urandom));
            end
        end
    endtask

    // Full store, then a count above the store size
    task automatic test_full_store();
        for (int j = 0; j < NPART; j++) load_random(j);
        cfg_write(REG_PART_COUNT, 128);
        send_item(REQ_UPDATE, $urandom_range(0, 127), 0, 0, 0);
        cfg_write(REG_PART_COUNT, 200);
        send_item(REQ_UPDATE, $urandom_range(0, 127), 0, 0, 0);
    endtask

    initial begin
        fail_cnt      = 0;
        idling_on     = 1'b1;
        holdoff_left  = 0;
        dim_mode      = 3;
        imbalance     = UNIT_Q12;
        soft_sq       = 0;
        step_q16      = 655;
        first_mob     = 0;
        part_count    = 96;
        aresetn          <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_index        <= '0;
        cfg_wr_data      <= '0;
        s_valid          <= 1'b0;
        s_req_type       <= REQ_LOAD;
        s_particle_index <= '0;
        s_pos_x          <= '0;
        s_pos_y          <= '0;
        s_pos_z          <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phase(1, 40, 1'b1);
        for (int p = 0; p < 24; p++) begin
            test_random_phase($urandom_range(0, 9) == 0 ? 8 : $urandom_range(0, 4), 40,
                              1'b0);
        end
        test_full_store();
        // closing stretch without idling on either side
        drain();
        idling_on = 1'b0;
        test_random_phase(3, 40, 1'b0);
        test_random_phase(2, 40, 1'b0);
        drain();

        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
